FILE: rtl/lei_pkg.sv
`timescale 1ns / 1ps

package lei_pkg;

  localparam int WORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 24;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 104;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_LAST = 5'd17;

  localparam logic [30:0] SIGMA_RST   = 31'd167772160;
  localparam logic [30:0] RHO_RST     = 31'd469762048;
  localparam logic [30:0] BETA_RST    = 31'd44739243;
  localparam logic [24:0] DT_RST      = 25'd167772;
  localparam logic [31:0] START_X_RST = 32'd1677722;
  localparam logic [31:0] START_Y_RST = 32'd0;
  localparam logic [31:0] START_Z_RST = 32'd0;
  localparam logic [24:0] SCALE_RST   = 25'd335544;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SIGMA   = 3'd0,
    REG_RHO     = 3'd1,
    REG_BETA    = 3'd2,
    REG_DT      = 3'd3,
    REG_START_X = 3'd4,
    REG_START_Y = 3'd5,
    REG_START_Z = 3'd6,
    REG_SCALE   = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_ADD,
    OP_SUB,
    OP_MUL
  } op_t;

  typedef enum logic [3:0] {
    SRC_X,
    SRC_Y,
    SRC_Z,
    SRC_T0,
    SRC_T1,
    SRC_T2,
    SRC_SIGMA,
    SRC_RHO,
    SRC_BETA,
    SRC_DT,
    SRC_SCALE
  } src_t;

  typedef enum logic [3:0] {
    DST_NONE,
    DST_X,
    DST_Y,
    DST_Z,
    DST_T0,
    DST_T1,
    DST_T2,
    DST_OX,
    DST_OY
  } dst_t;

  typedef enum logic [1:0] {
    SEQ_WAIT_IN,
    SEQ_NEXT,
    SEQ_PUSH
  } seq_t;

  typedef struct packed {
    op_t  op;
    src_t a;
    src_t b;
    dst_t dst;
    logic sat_en;
    seq_t seq;
  } ctrl_t;

  function automatic ctrl_t cw(input op_t op, input src_t a, input src_t b, input dst_t dst,
                               input logic sat_en, input seq_t seq);
    ctrl_t c;
    c.op     = op;
    c.a      = a;
    c.b      = b;
    c.dst    = dst;
    c.sat_en = sat_en;
    c.seq    = seq;
    return c;
  endfunction

  // dz first, then dy, then dx; x, y, z updated only once all derivatives exist
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] s);
    ctrl_t c;
    case (s)
      5'd0:    c = cw(OP_NOP, SRC_X,     SRC_X,     DST_NONE, 1'b0, SEQ_WAIT_IN);
      5'd1:    c = cw(OP_MUL, SRC_X,     SRC_Y,     DST_T0,   1'b1, SEQ_NEXT);
      5'd2:    c = cw(OP_MUL, SRC_BETA,  SRC_Z,     DST_T1,   1'b1, SEQ_NEXT);
      5'd3:    c = cw(OP_SUB, SRC_T0,    SRC_T1,    DST_T2,   1'b1, SEQ_NEXT);
      5'd4:    c = cw(OP_SUB, SRC_RHO,   SRC_Z,     DST_T0,   1'b1, SEQ_NEXT);
      5'd5:    c = cw(OP_MUL, SRC_X,     SRC_T0,    DST_T0,   1'b1, SEQ_NEXT);
      5'd6:    c = cw(OP_SUB, SRC_T0,    SRC_Y,     DST_T1,   1'b1, SEQ_NEXT);
      5'd7:    c = cw(OP_SUB, SRC_Y,     SRC_X,     DST_T0,   1'b1, SEQ_NEXT);
      5'd8:    c = cw(OP_MUL, SRC_SIGMA, SRC_T0,    DST_T0,   1'b1, SEQ_NEXT);
      5'd9:    c = cw(OP_MUL, SRC_T0,    SRC_DT,    DST_T0,   1'b1, SEQ_NEXT);
      5'd10:   c = cw(OP_ADD, SRC_X,     SRC_T0,    DST_X,    1'b1, SEQ_NEXT);
      5'd11:   c = cw(OP_MUL, SRC_T1,    SRC_DT,    DST_T1,   1'b1, SEQ_NEXT);
      5'd12:   c = cw(OP_ADD, SRC_Y,     SRC_T1,    DST_Y,    1'b1, SEQ_NEXT);
      5'd13:   c = cw(OP_MUL, SRC_T2,    SRC_DT,    DST_T2,   1'b1, SEQ_NEXT);
      5'd14:   c = cw(OP_ADD, SRC_Z,     SRC_T2,    DST_Z,    1'b1, SEQ_NEXT);
      5'd15:   c = cw(OP_MUL, SRC_X,     SRC_SCALE, DST_OX,   1'b0, SEQ_NEXT);
      5'd16:   c = cw(OP_MUL, SRC_Y,     SRC_SCALE, DST_OY,   1'b0, SEQ_NEXT);
      5'd17:   c = cw(OP_MUL, SRC_Z,     SRC_SCALE, DST_NONE, 1'b0, SEQ_PUSH);
      default: c = cw(OP_NOP, SRC_X,     SRC_X,     DST_NONE, 1'b0, SEQ_WAIT_IN);
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/lorenz_euler_integrator.sv
`timescale 1ns / 1ps

// Lorenz attractor point generator, forward Euler, signed fixed point.
// Input stream (s_*): one word per time step; s_tdata[0] is restart, which
// reloads x, y, z from start_x, start_y, start_z before the step.
// Output stream (m_*): one word per input word holding the new point times
// display_scale, each axis clipped to 32 bits, and the saturated flag.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr at the clock
// edge; write only while the block is idle.
// Sequencing: a short microprogram drives one shared saturating add/subtract
// and multiply unit, one operation per cycle unless the last step is held.
// An accepted word passes through the steps in order; the step counter
// returns to its wait step at the same edge at which the result is
// registered, and the next word can be taken in the cycle after that.
// The output word sits in its own register: while the receiver stalls the
// last step holds, and a new input word is taken as soon as the result has
// moved into that register.
// Reset (rst, synchronous): registers take their default values, x, y, z
// take the start values, and both streams go idle.
module lorenz_euler_integrator #(
  parameter int WORD_WIDTH = lei_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = lei_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [lei_pkg::IN_TDATA_W-1:0]  s_tdata,   // [0] restart
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [31:0] point_x, [63:32] point_y, [95:64] point_z, [96] saturated
  output logic [lei_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                            cfg_we,
  input  logic [lei_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [lei_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import lei_pkg::*;

  localparam int W   = WORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int XW0 = (2 * W - F > W + 1) ? 2 * W - F : W + 1;
  localparam int XW  = (XW0 > 33) ? XW0 : 33;
  localparam int OW  = (W > 32) ? W : 32;

  function automatic logic [W:0] clampw(input logic signed [XW-1:0] v);
    logic [XW-W:0] hi;
    logic          ovf;
    logic [W-1:0]  r;
    hi  = v[XW-1:W-1];
    ovf = !((&hi) || !(|hi));
    if (!ovf) begin
      r = v[W-1:0];
    end else if (v[XW-1]) begin
      r = {1'b1, {(W-1){1'b0}}};
    end else begin
      r = {1'b0, {(W-1){1'b1}}};
    end
    return {ovf, r};
  endfunction

  function automatic logic signed [W-1:0] reg_word(input logic [31:0] r, input logic sgn);
    logic signed [32:0] v;
    logic [W:0]         c;
    v = sgn ? $signed({r[31], r}) : $signed({1'b0, r});
    c = clampw(XW'(v));
    return c[W-1:0];
  endfunction

  function automatic logic [31:0] out32(input logic signed [W-1:0] v);
    logic signed [OW-1:0] e;
    logic [OW-32:0]       hi;
    logic [31:0]          r;
    e  = OW'(v);
    hi = e[OW-1:31];
    if ((&hi) || !(|hi)) begin
      r = e[31:0];
    end else if (e[OW-1]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7fff_ffff;
    end
    return r;
  endfunction

  logic [30:0] sigma_coef;
  logic [30:0] rho_coef;
  logic [30:0] beta_coef;
  logic [24:0] time_step;
  logic [31:0] start_x;
  logic [31:0] start_y;
  logic [31:0] start_z;
  logic [24:0] display_scale;

  logic signed [W-1:0] x, y, z, t0, t1, t2, ox, oy;
  logic                sat;
  logic [STEP_W-1:0]   step;

  ctrl_t                  ctrl;
  logic signed [W-1:0]    opa, opb;
  logic signed [2*W-1:0]  prod;
  logic signed [2*W-F-1:0] prod_sh;
  logic signed [XW-1:0]   wide;
  logic [W:0]             res;
  logic signed [W-1:0]    alu_val;
  logic                   alu_ovf;
  logic                   accept_in;
  logic                   out_free;
  logic                   push_out;

  function automatic logic signed [W-1:0] operand(input src_t s);
    logic signed [W-1:0] v;
    case (s)
      SRC_X:     v = x;
      SRC_Y:     v = y;
      SRC_Z:     v = z;
      SRC_T0:    v = t0;
      SRC_T1:    v = t1;
      SRC_T2:    v = t2;
      SRC_SIGMA: v = reg_word({1'b0, sigma_coef}, 1'b0);
      SRC_RHO:   v = reg_word({1'b0, rho_coef}, 1'b0);
      SRC_BETA:  v = reg_word({1'b0, beta_coef}, 1'b0);
      SRC_DT:    v = reg_word({7'd0, time_step}, 1'b0);
      SRC_SCALE: v = reg_word({7'd0, display_scale}, 1'b0);
      default:   v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    ctrl    = ucode(step);
    opa     = operand(ctrl.a);
    opb     = operand(ctrl.b);
    prod    = (2 * W)'(opa) * (2 * W)'(opb);
    prod_sh = prod[2*W-1:F];
    case (ctrl.op)
      OP_ADD:  wide = XW'(opa) + XW'(opb);
      OP_SUB:  wide = XW'(opa) - XW'(opb);
      OP_MUL:  wide = XW'(prod_sh);
      default: wide = '0;
    endcase
    res     = clampw(wide);
    alu_val = res[W-1:0];
    alu_ovf = res[W];
  end

  assign s_tready  = (ctrl.seq == SEQ_WAIT_IN);
  assign accept_in = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign push_out  = (ctrl.seq == SEQ_PUSH) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      sigma_coef    <= SIGMA_RST;
      rho_coef      <= RHO_RST;
      beta_coef     <= BETA_RST;
      time_step     <= DT_RST;
      start_x       <= START_X_RST;
      start_y       <= START_Y_RST;
      start_z       <= START_Z_RST;
      display_scale <= SCALE_RST;
      x             <= reg_word(START_X_RST, 1'b1);
      y             <= reg_word(START_Y_RST, 1'b1);
      z             <= reg_word(START_Z_RST, 1'b1);
      sat           <= 1'b0;
      step          <= '0;
      m_tvalid      <= 1'b0;
      m_tdata       <= '0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_addr))
          REG_SIGMA:   sigma_coef    <= cfg_wdata[30:0];
          REG_RHO:     rho_coef      <= cfg_wdata[30:0];
          REG_BETA:    beta_coef     <= cfg_wdata[30:0];
          REG_DT:      time_step     <= cfg_wdata[24:0];
          REG_START_X: start_x       <= cfg_wdata;
          REG_START_Y: start_y       <= cfg_wdata;
          REG_START_Z: start_z       <= cfg_wdata;
          REG_SCALE:   display_scale <= cfg_wdata[24:0];
          default: ;
        endcase
      end

      if (push_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (ctrl.seq)
        SEQ_WAIT_IN: begin
          if (accept_in) begin
            step <= step + 1'b1;
            sat  <= 1'b0;
            if (s_tdata[0]) begin
              x <= reg_word(start_x, 1'b1);
              y <= reg_word(start_y, 1'b1);
              z <= reg_word(start_z, 1'b1);
            end
          end
        end
        SEQ_NEXT: begin
          step <= step + 1'b1;
          if (ctrl.sat_en && alu_ovf) begin
            sat <= 1'b1;
          end
          case (ctrl.dst)
            DST_X:   x  <= alu_val;
            DST_Y:   y  <= alu_val;
            DST_Z:   z  <= alu_val;
            DST_T0:  t0 <= alu_val;
            DST_T1:  t1 <= alu_val;
            DST_T2:  t2 <= alu_val;
            DST_OX:  ox <= alu_val;
            DST_OY:  oy <= alu_val;
            default: ;
          endcase
        end
        SEQ_PUSH: begin
          // hold here until the output register is free
          if (push_out) begin
            step    <= '0;
            m_tdata <= {7'd0, sat, out32(alu_val), out32(oy), out32(ox)};
          end
        end
        default: step <= '0;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept_in |=> step == 5'd1)
    else $error("step counter did not advance after an input word");

  a_push_holds: assert property (@(posedge clk) disable iff (rst)
    (ctrl.seq == SEQ_PUSH && !out_free) |=> step == STEP_LAST)
    else $error("last step left while the output register was full");

  a_push_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(step) == STEP_LAST)
    else $error("output word raised outside the last step");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= STEP_LAST)
    else $error("step counter beyond the microprogram");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (step != '0) |-> !s_tready)
    else $error("input taken while a step is in progress");

endmodule
